// ===== hw/rtl/oerc_pkg.sv =====
// Shared types and constants for the overwriting event ring.
`default_nettype none

package oerc_pkg;

  localparam int unsigned RING_DEPTH = 64;
  localparam int unsigned SEQ_W      = 64;
  localparam int unsigned PEND_W     = 7;
  localparam int unsigned CFG_W      = 32;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_GET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [63:0] cursor;
    logic [63:0] timestamp;
    logic        kind;
    logic [31:0] flags;
    logic [63:0] payload_a;
    logic [63:0] payload_b;
    logic [63:0] payload_c;
  } in_word_t;

  typedef struct packed {
    logic              found;
    logic [63:0]       cursor_out;
    logic [PEND_W-1:0] pending_count;
    logic [63:0]       next_sequence;
    logic [63:0]       event_sequence;
    logic [63:0]       time_out;
    logic              kind_out;
    logic [31:0]       flags_out;
    logic [31:0]       lost_count;
    logic [63:0]       word_a_out;
    logic [63:0]       word_b_out;
    logic [63:0]       word_c_out;
  } out_word_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] flags;
    logic [63:0] time_stamp;
    logic [63:0] word_a;
    logic [63:0] word_b;
    logic [63:0] word_c;
  } ring_entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/oerc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module oerc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/overwriting_event_ring_with_cursor.sv =====
// Top level: overwriting event ring with reader sequence cursor.
// Result path: an accepted word goes through the ring RAM read (stage 1), then the result register.
// Throughput: one word per cycle; stalls only while the result register is held by the sink.
// Reset: sequence and cursor bookkeeping cleared, dropped mask set to 1, pipeline emptied.
// Ring contents are not cleared by reset or by a clear op; only written slots are ever read.
`default_nettype none

module overwriting_event_ring_with_cursor #(
  parameter int unsigned RingDepth = oerc_pkg::RING_DEPTH
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire oerc_pkg::in_word_t          in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output oerc_pkg::out_word_t              out_data_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [oerc_pkg::CFG_W-1:0]  cfg_data_i
);

  localparam int unsigned AW    = $clog2(RingDepth);
  localparam int unsigned SW    = oerc_pkg::SEQ_W;
  localparam int unsigned PW    = oerc_pkg::PEND_W;
  localparam logic [AW:0]   DepthW   = (AW+1)'(RingDepth);
  localparam logic [AW-1:0] LastSlot = AW'(RingDepth - 1);

  // sequence state
  logic [SW-1:0]          seq_q, seq_d;
  logic [SW-1:0]          oldest_q, oldest_d;
  logic [AW-1:0]          wslot_q, wslot_d;
  logic [oerc_pkg::CFG_W-1:0] mask_q;

  // stage 1 (RAM read in flight)
  logic                   s1_valid_q;
  oerc_pkg::opcode_e      s1_op_q;
  logic [SW-1:0]          s1_cursor_q;
  logic [SW-1:0]          s1_clamped_q;
  logic                   s1_clamp_q;
  logic [SW-1:0]          s1_seq_q;
  logic [SW-1:0]          s1_next_q;
  logic [SW-1:0]          s1_oldest_q;

  // result register
  logic                   out_valid_q;
  oerc_pkg::out_word_t    out_q;

  logic                   in_acc;
  logic                   s1_adv;
  logic                   clamp;
  logic [SW-1:0]          clamped;
  logic [AW:0]            diff;
  logic [AW:0]            wslot_ext;
  logic [AW:0]            rslot_wide;
  logic [AW-1:0]          rslot;
  logic                   ram_we;
  oerc_pkg::ring_entry_t  wentry;
  oerc_pkg::ring_entry_t  rentry;

  logic                   hit;
  logic [SW-1:0]          lost_diff;
  logic [31:0]            lost;
  oerc_pkg::out_word_t    res;

  assign cfg_ready_o = 1'b1;
  assign s1_adv      = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o  = ~s1_valid_q | s1_adv;
  assign in_acc      = in_valid_i & in_ready_o;

  // clamp cursor to the oldest retained sequence and find its slot
  assign clamp      = in_data_i.cursor < oldest_q;
  assign clamped    = clamp ? oldest_q : in_data_i.cursor;
  assign diff       = seq_q[AW:0] - clamped[AW:0];
  assign wslot_ext  = {1'b0, wslot_q};

  always_comb begin
    if (wslot_ext >= diff) begin
      rslot_wide = wslot_ext - diff;
    end else begin
      rslot_wide = wslot_ext + DepthW - diff;
    end
  end

  assign rslot = rslot_wide[AW-1:0];

  always_comb begin
    wentry.kind       = in_data_i.kind;
    wentry.flags      = in_data_i.flags;
    wentry.time_stamp = in_data_i.timestamp;
    wentry.word_a     = in_data_i.payload_a;
    wentry.word_b     = in_data_i.kind ? in_data_i.payload_b
                                       : {32'd0, in_data_i.payload_b[31:0]};
    wentry.word_c     = in_data_i.kind ? in_data_i.payload_c : 64'd0;
  end

  assign ram_we = in_acc & (in_data_i.opcode == oerc_pkg::OP_PUT);

  oerc_ram #(
    .Width ($bits(oerc_pkg::ring_entry_t)),
    .Depth (RingDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wslot_q),
    .wdata_i (wentry),
    .re_i    (in_acc),
    .raddr_i (rslot),
    .rdata_o (rentry)
  );

  always_comb begin
    seq_d    = seq_q;
    oldest_d = oldest_q;
    wslot_d  = wslot_q;
    unique case (in_data_i.opcode)
      oerc_pkg::OP_PUT: begin
        seq_d   = seq_q + 1'b1;
        wslot_d = (wslot_q == LastSlot) ? '0 : wslot_q + 1'b1;
        if (&seq_q) begin
          oldest_d = '0;
        end else if (seq_q >= SW'(RingDepth)) begin
          oldest_d = oldest_q + 1'b1;
        end
      end
      oerc_pkg::OP_CLEAR: begin
        seq_d    = '0;
        oldest_d = '0;
        wslot_d  = '0;
      end
      oerc_pkg::OP_GET, oerc_pkg::OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= '0;
      oldest_q    <= '0;
      wslot_q     <= '0;
      mask_q      <= oerc_pkg::CFG_W'(1);
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i & cfg_ready_o) begin
        mask_q <= cfg_data_i;
      end
      if (in_acc) begin
        seq_q    <= seq_d;
        oldest_q <= oldest_d;
        wslot_q  <= wslot_d;
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q      <= in_data_i.opcode;
      s1_cursor_q  <= in_data_i.cursor;
      s1_clamped_q <= clamped;
      s1_clamp_q   <= clamp;
      s1_seq_q     <= seq_q;
      s1_next_q    <= seq_d;
      s1_oldest_q  <= oldest_q;
    end
    if (s1_adv) begin
      out_q <= res;
    end
  end

  // stage 1: assemble the result word
  assign hit       = s1_clamped_q < s1_seq_q;
  assign lost_diff = s1_oldest_q - s1_cursor_q;
  assign lost      = s1_clamp_q ? ((|lost_diff[SW-1:32]) ? '1 : lost_diff[31:0]) : '0;

  always_comb begin
    res                = '0;
    res.cursor_out     = s1_cursor_q;
    res.next_sequence  = s1_next_q;
    res.pending_count  = hit ? (s1_seq_q[PW-1:0] - s1_clamped_q[PW-1:0]) : '0;
    unique case (s1_op_q)
      oerc_pkg::OP_PUT: begin
        res.event_sequence = s1_seq_q;
      end
      oerc_pkg::OP_GET: begin
        res.cursor_out = s1_clamped_q + SW'(hit);
        if (hit) begin
          res.found          = 1'b1;
          res.event_sequence = s1_clamped_q;
          res.time_out       = rentry.time_stamp;
          res.kind_out       = rentry.kind;
          res.flags_out      = rentry.flags | (s1_clamp_q ? mask_q : '0);
          res.lost_count     = lost;
          res.word_a_out     = rentry.word_a;
          res.word_b_out     = rentry.word_b;
          res.word_c_out     = rentry.word_c;
        end
      end
      oerc_pkg::OP_CLEAR, oerc_pkg::OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/oerc_checker.sv =====
// Port-level checker for the event ring, bound to the top level.
`default_nettype none

module oerc_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_o,
  input wire oerc_pkg::in_word_t         in_data_i,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire oerc_pkg::out_word_t        out_data_o,
  input wire logic                       cfg_valid_i,
  input wire logic                       cfg_ready_o,
  input wire logic [oerc_pkg::CFG_W-1:0] cfg_data_i
);

  logic unused_in;
  assign unused_in = in_valid_i ^ cfg_valid_i ^ cfg_ready_o ^ (^cfg_data_i) ^ (^in_data_i);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  a_miss_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |->
      out_data_o.lost_count == 32'd0 && out_data_o.time_out == 64'd0 &&
      out_data_o.word_a_out == 64'd0)
    else $error("event fields set on a result with no event");

  a_hit_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.found |->
      out_data_o.cursor_out == out_data_o.event_sequence + 64'd1)
    else $error("advanced cursor does not follow returned event");

endmodule

bind overwriting_event_ring_with_cursor oerc_checker u_oerc_checker (.*);

`default_nettype wire
